>>> sv/session_file_descrambler_core_defines.svh
// Assertion macros used by the descrambler's port-level checker file.
// Each macro expects clk and rst_n in scope of the caller.
`ifndef SESSION_FILE_DESCRAMBLER_CORE_DEFINES_SVH
`define SESSION_FILE_DESCRAMBLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sfd_pkg.sv
// Shared types, codes and keystream secret function for the file descrambler.
// No dependencies; used by the core and its checker.
package sfd_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_KEY_MODE = 8'd0;
  localparam logic [7:0] REG_KEY_STEP = 8'd1;

  // Scramble modes
  localparam logic [7:0] MODE_PLAIN  = 8'h00;
  localparam logic [7:0] MODE_FLIP   = 8'h80;
  localparam logic [7:0] MODE_SEC_LO = 8'h40;
  localparam logic [7:0] MODE_SEC_HI = 8'hC0;

  localparam logic [31:0] LO_WORDS [16] = '{
    32'haaaaaaaa, 32'haa955555, 32'ha9554aaa, 32'ha552a955,
    32'hb56ad5aa, 32'h95a95a95, 32'h94a5294a, 32'h9696b4b5,
    32'hd2d25a5a, 32'hd24b6d25, 32'hdb6db6da, 32'hd9249b6d,
    32'hc9b64d92, 32'hcd93264d, 32'hccd99b32, 32'hcccccccd
  };

  localparam logic [31:0] MIX_WORDS [16] = '{
    32'h00000000, 32'h00000b00, 32'h000100b0, 32'h00b0b010,
    32'h010b0b01, 32'h0b10b10b, 32'h01bb101b, 32'h0111bbbb,
    32'h1111bbbb, 32'h1bbb10bb, 32'h1bb0bb0b, 32'hbb0b0bab,
    32'hbab0b0ba, 32'hb0abaaba, 32'hba0aabaa, 32'hbaaaaaaa
  };

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       bad_mode;
  } out_item_t;

  // Derive the 64-bit mask secret from the step byte
  function automatic logic [63:0] secret_of(input logic [7:0] step);
    logic [6:0]  wrap;
    logic [6:0]  idx;
    logic        low_flag;
    logic [3:0]  sel;
    logic [31:0] lo;
    logic [31:0] mk;
    logic [31:0] rev;
    wrap     = step[6:0];
    idx      = wrap;
    low_flag = 1'b0;
    // mirror the upper half of the index range
    if (wrap[6]) begin
      low_flag = 1'b1;
      idx      = 7'(8'h80 - {1'b0, wrap});
    end
    sel = idx[4:1];
    if (idx[5]) begin
      sel = 4'hF - sel;
    end
    lo = LO_WORDS[sel];
    mk = MIX_WORDS[sel];
    if (idx[5]) begin
      lo = lo ^ 32'haaaaaaab;
      mk = mk ^ 32'h10000000;
    end
    // reverse nibble order of the low word
    for (int k = 0; k < 8; k++) begin
      rev[4*(7-k) +: 4] = lo[4*k +: 4];
    end
    return {rev ^ mk, lo ^ {31'd0, low_flag}};
  endfunction

endpackage

>>> sv/session_file_descrambler_core.sv
// Session file descrambler: position counter, base ramp and keystream XOR.
// Depends on sfd_pkg for payload types, mode codes and the secret function.
//
// Usage:
//   cfg_*  : write key_mode (index 0) and key_step (index 1) while the block
//            is idle; cfg_ready is always high. Other indexes are ignored.
//   in_*   : one scrambled byte per item; restart marks the first byte of a
//            file and resets the position to 0 and the ramp to key_mode.
//   out_*  : one result item per input item, in order: plain byte and a
//            bad_mode flag (plain byte reads 0 when the mode is unknown).
// Latency: an accepted item shows on out_valid in the next cycle.
// Throughput: one item per cycle; the single output register is the only
//   stage, and in_ready stays high while that register is empty or taken.
// Stall: while out_valid is high and out_ready low, the result holds and
//   in_ready drops until it is taken.
// Reset (rst_n low, synchronous): key registers, position and ramp clear to
//   zero and the output register empties.
// The secret mask is rebuilt in a register at each key_step write, so the
//   per-byte path is one ramp add, a bit select and the XOR.
module session_file_descrambler_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfd_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output sfd_pkg::out_item_t out_item
);
  import sfd_pkg::*;

  logic [7:0]  key_mode_r;
  logic [7:0]  key_step_r;
  logic [63:0] secret_r;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  ramp_r, ramp_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r, out_item_nxt;

  logic        in_fire;
  logic [7:0]  pos_cur;
  logic [7:0]  ramp_cur;
  logic [7:0]  ks;
  logic [1:0]  quarter;
  logic        sbit;
  logic        bad;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Apply restart before the byte is processed
  assign pos_cur  = in_item.restart ? 8'd0 : pos_r;
  assign ramp_cur = in_item.restart ? key_mode_r : ramp_r;
  assign quarter  = pos_cur[7:6];
  assign sbit     = secret_r[pos_cur[5:0]];

  // Select keystream by mode and quarter
  always_comb begin
    ks  = ramp_cur;
    bad = 1'b0;
    case (key_mode_r)
      MODE_PLAIN: begin
        ks = ramp_cur;
      end
      MODE_FLIP: begin
        if (quarter == 2'd0 || quarter == 2'd2) begin
          ks = ramp_cur ^ 8'h80;
        end
      end
      MODE_SEC_LO, MODE_SEC_HI: begin
        case (quarter)
          2'd0:    ks = ramp_cur ^ (sbit ? 8'hc0 : 8'h40);
          2'd2:    ks = ramp_cur ^ (sbit ? 8'h40 : 8'hc0);
          2'd3:    ks = ramp_cur ^ 8'h80;
          default: ks = ramp_cur;
        endcase
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // Form the result and advance position and ramp
  always_comb begin
    out_item_nxt.plain_byte = bad ? 8'd0 : (in_item.cipher_byte ^ ks);
    out_item_nxt.bad_mode   = bad;
    pos_nxt                 = pos_cur + 8'd1;
    if (pos_nxt[5:0] == 6'd0) begin
      ramp_nxt = key_mode_r;
    end else begin
      ramp_nxt = ramp_cur + key_step_r - key_mode_r;
    end
  end

  // Hold key registers and the derived secret
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= MODE_PLAIN;
      key_step_r <= 8'd0;
      secret_r   <= secret_of(8'd0);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KEY_MODE) begin
        key_mode_r <= cfg_wdata;
      end else if (cfg_index == REG_KEY_STEP) begin
        key_step_r <= cfg_wdata;
        secret_r   <= secret_of(cfg_wdata);
      end
    end
  end

  // Advance stream state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      ramp_r <= 8'd0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      ramp_r <= ramp_nxt;
    end
  end

  // Output register: fill on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

>>> sv/sfd_checker.sv
// Port-level checks for the descrambler core, bound to every instance.
// Depends on sfd_pkg and session_file_descrambler_core_defines.svh.
`include "session_file_descrambler_core_defines.svh"

module sfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sfd_pkg::out_item_t out_item
);

  // a stalled result keeps the output channel busy
  `SFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // the single output register blocks input while it holds a stalled item
  `SFD_ASSERT_NOW(a_full_blocks, out_valid && !out_ready, !in_ready, "input taken into a full stage")
  // every accepted item shows a result in the next cycle
  `SFD_ASSERT_NEXT(a_one_cycle, in_valid && in_ready, out_valid, "result missing after accept")
  // an unknown mode never leaks a plain byte
  `SFD_ASSERT_NOW(a_bad_zero, out_valid && out_item.bad_mode, out_item.plain_byte == 8'd0,
                  "plain byte set with bad mode")

endmodule

bind session_file_descrambler_core sfd_checker u_sfd_checker (.*);

>>> test/session_file_descrambler_checker.sv
// Checker for the file descrambler: watches the key, input and result channels,
// predicts each plain byte and compares results in order.
// Depends on sfd_pkg for the payload structs, register indexes and mode codes.
`timescale 1ns / 100ps

module session_file_descrambler_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sfd_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfd_pkg::out_item_t  out_item,
  output int                  outstanding,
  output int                  fail_count
);
  import sfd_pkg::*;

  // Secret seed words, indexed by the folded step
  localparam logic [31:0] SEED_LOW [16] = '{
    32'haaaaaaaa, 32'haa955555, 32'ha9554aaa, 32'ha552a955,
    32'hb56ad5aa, 32'h95a95a95, 32'h94a5294a, 32'h9696b4b5,
    32'hd2d25a5a, 32'hd24b6d25, 32'hdb6db6da, 32'hd9249b6d,
    32'hc9b64d92, 32'hcd93264d, 32'hccd99b32, 32'hcccccccd
  };
  localparam logic [31:0] SEED_TWIST [16] = '{
    32'h00000000, 32'h00000b00, 32'h000100b0, 32'h00b0b010,
    32'h010b0b01, 32'h0b10b10b, 32'h01bb101b, 32'h0111bbbb,
    32'h1111bbbb, 32'h1bbb10bb, 32'h1bb0bb0b, 32'hbb0b0bab,
    32'hbab0b0ba, 32'hb0abaaba, 32'hba0aabaa, 32'hbaaaaaaa
  };

  logic [7:0]  key_mode_q = 8'h00;
  logic [7:0]  key_step_q = 8'h00;
  logic [7:0]  file_pos   = 8'h00;
  logic [7:0]  ramp_acc   = 8'h00;
  out_item_t   plain_q[$];

  // Build the 64-bit mask pattern for one step byte
  function automatic logic [63:0] mask_pattern(input logic [7:0] step);
    logic [6:0]  folded;
    logic        upper_half;
    logic [3:0]  row;
    logic [31:0] low_w;
    logic [31:0] twist_w;
    logic [31:0] swapped;
    upper_half = step[6];
    folded     = step[6:0];
    // mirror steps with bit 6 set back into the lower range
    if (upper_half) begin
      folded = 7'(8'd128 - {1'b0, step[6:0]});
    end
    row = folded[5] ? ~folded[4:1] : folded[4:1];
    low_w   = SEED_LOW[row];
    twist_w = SEED_TWIST[row];
    if (folded[5]) begin
      low_w   = low_w ^ 32'haaaaaaab;
      twist_w = twist_w ^ 32'h10000000;
    end
    for (int n = 0; n < 8; n++) begin
      swapped[31 - 4*n -: 4] = low_w[4*n +: 4];
    end
    return {swapped ^ twist_w, low_w[31:1], low_w[0] ^ upper_half};
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    out_item_t   got;
    logic [7:0]  at;
    logic [7:0]  base;
    logic [7:0]  ks;
    logic [7:0]  next_pos;
    logic [63:0] pattern;
    logic        mask_bit;
    if (!rst_n) begin
      key_mode_q = 8'h00;
      key_step_q = 8'h00;
      file_pos   = 8'h00;
      ramp_acc   = 8'h00;
      fail_count = 0;
      plain_q.delete();
    end else begin
      // compare the result taken at this edge with the oldest prediction
      if (out_valid && out_ready) begin
        got = out_item;
        if (plain_q.size() == 0) begin
          flag_mismatch("unexpected result", -1, int'(got));
        end else begin
          want = plain_q.pop_front();
          if (want.plain_byte !== got.plain_byte) begin
            flag_mismatch("plain_byte", want.plain_byte, got.plain_byte);
          end
          if (want.bad_mode !== got.bad_mode) begin
            flag_mismatch("bad_mode", want.bad_mode, got.bad_mode);
          end
        end
      end

      // predict the plain byte for an accepted item and advance position and ramp
      if (in_valid && in_ready) begin
        at   = in_item.restart ? 8'h00 : file_pos;
        base = in_item.restart ? key_mode_q : ramp_acc;
        ks   = base;
        want.bad_mode = 1'b0;
        case (key_mode_q)
          MODE_PLAIN: ;
          MODE_FLIP: begin
            if (!at[6]) ks = ks ^ 8'h80;
          end
          MODE_SEC_LO, MODE_SEC_HI: begin
            pattern  = mask_pattern(key_step_q);
            mask_bit = pattern[at[5:0]];
            case (at[7:6])
              2'd0: ks = ks ^ (mask_bit ? 8'hc0 : 8'h40);
              2'd2: ks = ks ^ (mask_bit ? 8'h40 : 8'hc0);
              2'd3: ks = ks ^ 8'h80;
              default: ;
            endcase
          end
          default: want.bad_mode = 1'b1;
        endcase
        want.plain_byte = want.bad_mode ? 8'h00 : (in_item.cipher_byte ^ ks);
        plain_q = {plain_q, want};

        next_pos = at + 8'd1;
        file_pos = next_pos;
        ramp_acc = (next_pos[5:0] == 6'd0) ? key_mode_q : 8'(base + key_step_q - key_mode_q);
      end

      // track key writes; other indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_MODE: key_mode_q = cfg_wdata;
          REG_KEY_STEP: key_step_q = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= plain_q.size();
  end

endmodule

>>> test/session_file_descrambler_core_test.sv
// Top of the descrambler testbench: clock, reset, key writes, byte stimulus
// and the verdict. Depends on sfd_pkg, the core and session_file_descrambler_checker.
`timescale 1ns / 100ps

module session_file_descrambler_core_test;
  import sfd_pkg::*;

  // Unknown mode codes used by the directed part
  localparam logic [7:0] MODE_JUNK_LOW  = 8'h01;
  localparam logic [7:0] MODE_JUNK_HIGH = 8'hFF;

  localparam logic [7:0] PROBE_MODES [6] = '{
    MODE_PLAIN, MODE_FLIP, MODE_SEC_LO, MODE_SEC_HI, MODE_JUNK_LOW, MODE_JUNK_HIGH
  };
  localparam logic [7:0] PROBE_STEPS [6] = '{8'h00, 8'hFF, 8'h00, 8'h7F, 8'h40, 8'h80};
  localparam logic [7:0] PROBE_BYTES [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
  localparam logic [7:0] STEP_EDGES  [9] = '{
    8'h00, 8'hFF, 8'h40, 8'h7F, 8'h80, 8'hC0, 8'h20, 8'h3F, 8'h60
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  int         outstanding;
  int         fail_count;
  int         send_idle_pct = 11;
  int         recv_idle_pct = 76;

  session_file_descrambler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  session_file_descrambler_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic put_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load both keys, with a write to an unused index in between
  task automatic load_keys(input logic [7:0] mode, input logic [7:0] step);
    put_reg(REG_KEY_MODE, mode);
    put_reg(8'($urandom_range(255, 2)), 8'($urandom_range(255)));
    put_reg(REG_KEY_STEP, step);
    cfg_valid <= 1'b0;
  endtask

  // Offer one cipher byte, idling first at the current rate
  task automatic send_byte(input logic [7:0] cipher, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{cipher_byte: cipher, restart: restart};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off until every predicted byte has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] mode;
    logic [7:0] step;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every mode, step extremes, byte extremes, restarts, mid-stream key change
    for (int p = 0; p < 6; p++) begin
      load_keys(PROBE_MODES[p], PROBE_STEPS[p]);
      for (int k = 0; k < 4; k++) begin
        send_byte(PROBE_BYTES[k], (k == 0 && p != 1) || k == 3);
      end
      drain();
    end

    // Random phases; keys change between phases, often without a restart
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 76;
        recv_idle_pct = 11;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0, 1:    mode = MODE_PLAIN;
        2, 3:    mode = MODE_FLIP;
        4, 5:    mode = MODE_SEC_LO;
        6, 7:    mode = MODE_SEC_HI;
        default: mode = 8'($urandom_range(255));
      endcase
      step = ($urandom_range(2) == 0) ? STEP_EDGES[$urandom_range(8)]
                                      : 8'($urandom_range(255));
      load_keys(mode, step);
      for (int k = 0; k < 42; k++) begin
        send_byte(8'($urandom_range(255)),
                  (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(255) == 0));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
